[hw/rtl/sensor_poll_health_monitor_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sensor poll health monitor
// Concurrent checks on clk, with or without reset masking.
// Build with ASSERT_OFF set to drop every check.
// ----------------------------------------------------------------------------
`ifndef SENSOR_POLL_HEALTH_MONITOR_DEFINES_SVH
`define SENSOR_POLL_HEALTH_MONITOR_DEFINES_SVH

`ifndef ASSERT_OFF
// check masked while rst is high
`define SPM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check that also holds during reset
`define SPM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPM_ASSERT(label, prop, msg)
`define SPM_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[hw/rtl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the sensor poll health monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spm_pkg;

  localparam int unsigned WINDOW_DEFAULT = 16;
  localparam int unsigned NUM_SENSORS    = 5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_SENSOR_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_CYCLE_THR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HIGH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_LOW       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HUMID_HIGH      = 3'd5;

  // register reset values
  localparam logic [2:0]         RST_FAIL_SENSOR_THR = 3'd3;
  localparam logic [15:0]        RST_FAIL_CYCLE_THR  = 16'd3;
  localparam logic signed [15:0] RST_TEMP_LOW        = -16'sd400;
  localparam logic signed [15:0] RST_TEMP_HIGH       = 16'sd800;
  localparam logic signed [15:0] RST_HUMID_LOW       = 16'sd0;
  localparam logic signed [15:0] RST_HUMID_HIGH      = 16'sd1000;

  localparam logic [15:0] BAD_COUNT_MAX = 16'hFFFF;
  localparam logic [38:0] LUX_SCALE     = 39'd100;

  // ok_mask bit positions
  localparam int unsigned OK_NOISE   = 0;
  localparam int unsigned OK_CO2     = 1;
  localparam int unsigned OK_NH3     = 2;
  localparam int unsigned OK_LIGHT   = 3;
  localparam int unsigned OK_CLIMATE = 4;

  typedef struct packed {
    logic              noise_ok;
    logic signed [15:0] noise_raw;
    logic              co2_ok;
    logic signed [15:0] co2_raw;
    logic              nh3_ok;
    logic signed [15:0] nh3_raw;
    logic              light_ok;
    logic [31:0]       light_raw;
    logic              climate_ok;
    logic signed [15:0] temp_raw;
    logic signed [15:0] humid_raw;
  } spm_in_t;

  typedef struct packed {
    logic [4:0]         ok_mask;
    logic signed [15:0] sound_tenths;
    logic signed [15:0] co2_ppm;
    logic signed [15:0] nh3_ppm;
    logic [38:0]        light_scaled;
    logic signed [15:0] temp_tenths;
    logic signed [15:0] humid_tenths;
    logic [2:0]         failed_count;
    logic               bus_failure;
    logic               baseline_ready;
    logic signed [15:0] sound_baseline;
    logic               reading_valid;
  } spm_out_t;

  typedef struct packed {
    logic [2:0]         fail_sensor_threshold;
    logic [15:0]        fail_cycle_threshold;
    logic signed [15:0] temp_low_tenths;
    logic signed [15:0] temp_high_tenths;
    logic signed [15:0] humid_low_tenths;
    logic signed [15:0] humid_high_tenths;
  } spm_cfg_t;

  typedef struct packed {
    logic [2:0] failed_count;
    logic       bus_failure;
    logic       reading_valid;
  } spm_health_t;

  typedef struct packed {
    logic               ready;
    logic signed [15:0] baseline;
  } spm_ring_t;

endpackage

[hw/rtl/spm_ram.sv]
// ----------------------------------------------------------------------------
// spm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/spm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// spm_cfg_regs
// Threshold and range registers behind the plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             we,
  input  logic [spm_pkg::CFG_IDX_W-1:0]    index,
  input  logic [spm_pkg::CFG_DATA_W-1:0]   data,
  output spm_pkg::spm_cfg_t                cfg
);

  import spm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fail_sensor_threshold <= RST_FAIL_SENSOR_THR;
      cfg.fail_cycle_threshold  <= RST_FAIL_CYCLE_THR;
      cfg.temp_low_tenths       <= RST_TEMP_LOW;
      cfg.temp_high_tenths      <= RST_TEMP_HIGH;
      cfg.humid_low_tenths      <= RST_HUMID_LOW;
      cfg.humid_high_tenths     <= RST_HUMID_HIGH;
    end else if (we) begin
      unique case (index)
        CFG_FAIL_SENSOR_THR: cfg.fail_sensor_threshold <= data[2:0];
        CFG_FAIL_CYCLE_THR:  cfg.fail_cycle_threshold  <= data;
        CFG_TEMP_LOW:        cfg.temp_low_tenths       <= data;
        CFG_TEMP_HIGH:       cfg.temp_high_tenths      <= data;
        CFG_HUMID_LOW:       cfg.humid_low_tenths      <= data;
        CFG_HUMID_HIGH:      cfg.humid_high_tenths     <= data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

[hw/rtl/spm_health.sv]
// ----------------------------------------------------------------------------
// spm_health
// Failed-sensor count, consecutive bad-cycle counter and climate range check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spm_health (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [4:0]          ok_mask,
  input  logic signed [15:0]  temp,
  input  logic signed [15:0]  humid,
  input  spm_pkg::spm_cfg_t   cfg,
  output spm_pkg::spm_health_t stat
);

  import spm_pkg::*;

  logic [15:0] bad_cycle_count;
  logic [15:0] bad_cycle_count_next;
  logic [2:0]  ok_ones;
  logic [2:0]  failed;
  logic        bad_cycle;

  always_comb begin
    ok_ones = '0;
    for (int i = 0; i < int'(NUM_SENSORS); i++) begin
      ok_ones = ok_ones + 3'(ok_mask[i]);
    end
    failed    = 3'(NUM_SENSORS) - ok_ones;
    bad_cycle = failed >= cfg.fail_sensor_threshold;

    bad_cycle_count_next = bad_cycle_count;
    if (step) begin
      if (!bad_cycle) begin
        bad_cycle_count_next = '0;
      end else if (bad_cycle_count != BAD_COUNT_MAX) begin
        bad_cycle_count_next = bad_cycle_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_cycle_count <= '0;
    end else begin
      bad_cycle_count <= bad_cycle_count_next;
    end
  end

  assign stat.failed_count  = failed;
  assign stat.bus_failure   = bad_cycle_count_next >= cfg.fail_cycle_threshold;
  assign stat.reading_valid = ok_mask[OK_CLIMATE] &&
                              temp >= cfg.temp_low_tenths &&
                              temp <= cfg.temp_high_tenths &&
                              humid >= cfg.humid_low_tenths &&
                              humid <= cfg.humid_high_tenths;

endmodule

[hw/rtl/spm_ring_mean.sv]
// ----------------------------------------------------------------------------
// spm_ring_mean
// Sound sample ring with running sum and truncated window mean.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sensor_poll_health_monitor_defines.svh"

module spm_ring_mean #(
  parameter int unsigned WINDOW = spm_pkg::WINDOW_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               sample_ok,
  input  logic signed [15:0] sample,
  output spm_pkg::spm_ring_t stat
);

  import spm_pkg::*;

  localparam int unsigned PTR_W   = $clog2(WINDOW);
  localparam int unsigned SUM_W   = 16 + PTR_W;
  // floor(n / WINDOW) == (n * RECIP) >> (SUM_W + PTR_W) for n < 2**SUM_W
  localparam int unsigned SHIFT   = SUM_W + PTR_W;
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

  logic [PTR_W-1:0]        ring_pointer, ring_pointer_next;
  logic signed [SUM_W-1:0] ring_sum, ring_sum_next;
  logic                    ring_filled, ring_filled_next;
  logic signed [15:0]      baseline_hold, baseline_hold_next;

  logic [15:0]             rd_q;
  logic signed [15:0]      old_sample;
  logic signed [SUM_W-1:0] sum_upd;
  logic                    wrap;
  logic                    sum_neg;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W+RECIP_W-1:0] prod;
  logic [15:0]             q_mag;
  logic signed [15:0]      mean;
  logic                    write_en;

  // rd_q always holds the entry at ring_pointer: the read address tracks the
  // pointer's next value, and the write goes to the slot being left.
  spm_ram #(
    .WIDTH(16),
    .DEPTH(WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (write_en),
    .waddr(ring_pointer),
    .wdata(sample),
    .raddr(ring_pointer_next),
    .rdata(rd_q)
  );

  always_comb begin
    write_en   = step && sample_ok;
    // slots at or past the pointer are unwritten (zero) until the first wrap
    old_sample = ring_filled ? signed'(rd_q) : 16'sd0;
    sum_upd    = ring_sum - SUM_W'(old_sample) + SUM_W'(sample);
    wrap       = ring_pointer == PTR_LAST;

    sum_neg = sum_upd[SUM_W-1];
    sum_mag = sum_neg ? SUM_W'(-sum_upd) : SUM_W'(sum_upd);
    prod    = {{RECIP_W{1'b0}}, sum_mag} * {{SUM_W{1'b0}}, RECIP};
    q_mag   = prod[SHIFT +: 16];
    mean    = sum_neg ? signed'(16'(-q_mag)) : signed'(q_mag);

    ring_pointer_next  = ring_pointer;
    ring_sum_next      = ring_sum;
    ring_filled_next   = ring_filled;
    baseline_hold_next = baseline_hold;
    if (write_en) begin
      ring_pointer_next = wrap ? '0 : ring_pointer + PTR_W'(1);
      ring_sum_next     = sum_upd;
      ring_filled_next  = ring_filled || wrap;
      if (ring_filled || wrap) begin
        baseline_hold_next = mean;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_pointer  <= '0;
      ring_sum      <= '0;
      ring_filled   <= 1'b0;
      baseline_hold <= '0;
    end else begin
      ring_pointer  <= ring_pointer_next;
      ring_sum      <= ring_sum_next;
      ring_filled   <= ring_filled_next;
      baseline_hold <= baseline_hold_next;
    end
  end

  assign stat.ready    = ring_filled_next;
  assign stat.baseline = baseline_hold_next;

  `SPM_ASSERT(a_baseline_zero_until_filled, !ring_filled |-> baseline_hold == 16'sd0, "baseline set before ring filled")
  `SPM_ASSERT(a_wrap_sets_filled, write_en && wrap |=> ring_filled && ring_pointer == '0, "wrap did not mark ring filled")
  `SPM_ASSERT(a_hold_without_sample, step && !sample_ok |=> $stable(ring_pointer) && $stable(ring_sum), "ring moved without a sample")

endmodule

[hw/rtl/sensor_poll_health_monitor.sv]
// ----------------------------------------------------------------------------
// sensor_poll_health_monitor
// Scales one five-sensor poll cycle per request and tracks bus health and a
// sound baseline.
// ----------------------------------------------------------------------------
// Takes one poll request per clock while the result register is not held by
// out_stall; the request is captured in the input register and its result
// in the result register, which holds it until it is taken. The rate is set
// by the sound ring: at most one RAM write and one registered read per clock,
// with a running sum so the window mean needs no pass over the ring. The ring
// needs no clearing pass after reset; slots not yet written read as zero until
// the pointer first wraps. Configuration writes are taken at any time but
// should only be made while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_poll_health_monitor #(
  parameter int unsigned WINDOW = spm_pkg::WINDOW_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // poll request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  spm_pkg::spm_in_t               in_data,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output spm_pkg::spm_out_t              out_data,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [spm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import spm_pkg::*;

  // Stage 1: captured request. Stage 2: result register. A request moves
  // from stage 1 to stage 2 whenever the result register is empty or being
  // taken, so the two sides only couple through that one decision.
  logic     s1_valid;
  spm_in_t  s1_data;
  logic     s1_adv;
  logic     in_take;

  spm_cfg_t    cfg;
  spm_health_t health;
  spm_ring_t   ring;
  spm_out_t    result;
  logic [4:0]  mask;

  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_data <= in_data;
    end
    if (s1_adv) begin
      out_data <= result;
    end
  end

  spm_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .we   (cfg_we),
    .index(cfg_index),
    .data (cfg_data),
    .cfg  (cfg)
  );

  always_comb begin
    mask             = '0;
    mask[OK_NOISE]   = s1_data.noise_ok;
    mask[OK_CO2]     = s1_data.co2_ok;
    mask[OK_NH3]     = s1_data.nh3_ok;
    mask[OK_LIGHT]   = s1_data.light_ok;
    mask[OK_CLIMATE] = s1_data.climate_ok;
  end

  // Health state (bad-cycle counter) advances with the request leaving stage 1.
  spm_health u_health (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_adv),
    .ok_mask(mask),
    .temp   (s1_data.temp_raw),
    .humid  (s1_data.humid_raw),
    .cfg    (cfg),
    .stat   (health)
  );

  // Sound ring takes the sample only when the sound read succeeded.
  spm_ring_mean #(
    .WINDOW(WINDOW)
  ) u_ring (
    .clk      (clk),
    .rst      (rst),
    .step     (s1_adv),
    .sample_ok(s1_data.noise_ok),
    .sample   (s1_data.noise_raw),
    .stat     (ring)
  );

  // Failed readings read as zero; light is scaled to hundredths exactly.
  always_comb begin
    result.ok_mask        = mask;
    result.sound_tenths   = s1_data.noise_ok   ? s1_data.noise_raw : 16'sd0;
    result.co2_ppm        = s1_data.co2_ok     ? s1_data.co2_raw   : 16'sd0;
    result.nh3_ppm        = s1_data.nh3_ok     ? s1_data.nh3_raw   : 16'sd0;
    result.light_scaled   = s1_data.light_ok ?
                            {7'd0, s1_data.light_raw} * LUX_SCALE : 39'd0;
    result.temp_tenths    = s1_data.climate_ok ? s1_data.temp_raw  : 16'sd0;
    result.humid_tenths   = s1_data.climate_ok ? s1_data.humid_raw : 16'sd0;
    result.failed_count   = health.failed_count;
    result.bus_failure    = health.bus_failure;
    result.baseline_ready = ring.ready;
    result.sound_baseline = ring.baseline;
    result.reading_valid  = health.reading_valid;
  end

endmodule

[tb/tb_sensor_poll_health_monitor.sv]
// ----------------------------------------------------------------------------
// tb_sensor_poll_health_monitor
// Drives poll requests through the health monitor under random source gaps and
// result back-pressure. A scoreboard class predicts every result and compares
// it field by field. The run covers several register settings and a gap-free
// run of bad cycles that climbs past the cycle threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sensor_poll_health_monitor;
  import spm_pkg::*;

  localparam int RING_LEN      = int'(WINDOW_DEFAULT);
  localparam int STALL_PCT     = 38;
  localparam int WATCHDOG_MAX  = 2000;   // cycles with no handshake on either side
  localparam int SETTLE_CYCLES = 4;      // idle falling edges after the last result is checked

  // --------------------------------------------------------------------------
  // Scoreboard: own copy of the register file and the health/ring state,
  // updated once per accepted poll request.
  // --------------------------------------------------------------------------
  class poll_health_scoreboard;
    bit [2:0]  sensor_thr;
    bit [15:0] cycle_thr;
    int        temp_lo, temp_hi, humid_lo, humid_hi;
    bit [15:0] bad_run;
    int        sound_ring[RING_LEN];
    int        ring_ptr;
    int        ring_total;
    bit        ring_full;
    logic signed [15:0] baseline;
    spm_out_t  pending_reports[$];
    int        failures;

    function new();
      sensor_thr = RST_FAIL_SENSOR_THR;
      cycle_thr  = RST_FAIL_CYCLE_THR;
      temp_lo    = RST_TEMP_LOW;
      temp_hi    = RST_TEMP_HIGH;
      humid_lo   = RST_HUMID_LOW;
      humid_hi   = RST_HUMID_HIGH;
      bad_run    = '0;
      foreach (sound_ring[i]) sound_ring[i] = 0;
      ring_ptr   = 0;
      ring_total = 0;
      ring_full  = 1'b0;
      baseline   = '0;
      failures   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_FAIL_SENSOR_THR: sensor_thr = value[2:0];
        CFG_FAIL_CYCLE_THR:  cycle_thr  = value;
        CFG_TEMP_LOW:        temp_lo    = $signed(value);
        CFG_TEMP_HIGH:       temp_hi    = $signed(value);
        CFG_HUMID_LOW:       humid_lo   = $signed(value);
        CFG_HUMID_HIGH:      humid_hi   = $signed(value);
        default: ;
      endcase
    endfunction

    // Accepted poll request: advance the state and queue the expected result.
    function void note_poll(spm_in_t p);
      spm_out_t   r;
      logic [4:0] mask;
      logic [63:0] lux;
      int         sample, t, h;
      mask = '0;
      mask[OK_NOISE]   = p.noise_ok;
      mask[OK_CO2]     = p.co2_ok;
      mask[OK_NH3]     = p.nh3_ok;
      mask[OK_LIGHT]   = p.light_ok;
      mask[OK_CLIMATE] = p.climate_ok;
      lux = {32'd0, p.light_raw} * 64'd100;

      r.ok_mask      = mask;
      r.sound_tenths = p.noise_ok   ? p.noise_raw : '0;
      r.co2_ppm      = p.co2_ok     ? p.co2_raw   : '0;
      r.nh3_ppm      = p.nh3_ok     ? p.nh3_raw   : '0;
      r.light_scaled = p.light_ok   ? lux[38:0]   : '0;
      r.temp_tenths  = p.climate_ok ? p.temp_raw  : '0;
      r.humid_tenths = p.climate_ok ? p.humid_raw : '0;
      r.failed_count = 3'(NUM_SENSORS - $countones(mask));

      // consecutive bad cycles, saturating
      if (r.failed_count >= sensor_thr) begin
        if (bad_run != BAD_COUNT_MAX) bad_run++;
      end else begin
        bad_run = '0;
      end
      r.bus_failure = (bad_run >= cycle_thr);

      // sound ring with running sum; a failed read leaves it alone
      if (p.noise_ok) begin
        sample = $signed(p.noise_raw);
        ring_total = ring_total - sound_ring[ring_ptr] + sample;
        sound_ring[ring_ptr] = sample;
        ring_ptr = (ring_ptr + 1) % RING_LEN;
        if (ring_ptr == 0) ring_full = 1'b1;
        if (ring_full) baseline = 16'(ring_total / RING_LEN);
      end
      r.baseline_ready = ring_full;
      r.sound_baseline = baseline;

      t = $signed(r.temp_tenths);
      h = $signed(r.humid_tenths);
      r.reading_valid = p.climate_ok && t >= temp_lo && t <= temp_hi &&
                        h >= humid_lo && h <= humid_hi;
      pending_reports.push_back(r);
    endfunction

    function void flag(string what, logic [38:0] want, logic [38:0] got);
      failures++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    endfunction

    function void check_field(string what, logic [38:0] want, logic [38:0] got);
      if (want !== got) flag(what, want, got);
    endfunction

    // Accepted result: compare with the oldest expectation.
    function void check_report(spm_out_t got);
      spm_out_t want;
      if (pending_reports.size() == 0) begin
        flag("unexpected result", '0, got.ok_mask);
        return;
      end
      want = pending_reports.pop_front();
      check_field("ok_mask",        want.ok_mask,        got.ok_mask);
      check_field("sound_tenths",   want.sound_tenths,   got.sound_tenths);
      check_field("co2_ppm",        want.co2_ppm,        got.co2_ppm);
      check_field("nh3_ppm",        want.nh3_ppm,        got.nh3_ppm);
      check_field("light_scaled",   want.light_scaled,   got.light_scaled);
      check_field("temp_tenths",    want.temp_tenths,    got.temp_tenths);
      check_field("humid_tenths",   want.humid_tenths,   got.humid_tenths);
      check_field("failed_count",   want.failed_count,   got.failed_count);
      check_field("bus_failure",    want.bus_failure,    got.bus_failure);
      check_field("baseline_ready", want.baseline_ready, got.baseline_ready);
      check_field("sound_baseline", want.sound_baseline, got.sound_baseline);
      check_field("reading_valid",  want.reading_valid,  got.reading_valid);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  spm_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  spm_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bit quiet;          // no gaps and no back-pressure while set
  int idle_cycles;
  poll_health_scoreboard sb = new();

  sensor_poll_health_monitor u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Result side: random back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
  end

  // Result monitor and watchdog, sampled on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) sb.check_report(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_MAX) begin
          $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_MAX);
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Full-range word with the extremes weighted in.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Climate values: mostly around and inside the configured window.
  function automatic logic [15:0] pick_climate(int lo, int hi);
    int v;
    if (lo > hi || $urandom_range(99) < 30) return pick_word();
    case ($urandom_range(5))
      0:       v = lo - 1;
      1:       v = lo;
      2:       v = hi;
      3:       v = hi + 1;
      default: v = lo + int'($urandom_range(hi - lo));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  function automatic spm_in_t random_poll(int fail_pct);
    spm_in_t p;
    p.noise_ok   = $urandom_range(99) >= fail_pct;
    p.co2_ok     = $urandom_range(99) >= fail_pct;
    p.nh3_ok     = $urandom_range(99) >= fail_pct;
    p.light_ok   = $urandom_range(99) >= fail_pct;
    p.climate_ok = $urandom_range(99) >= fail_pct;
    p.noise_raw  = pick_word();
    p.co2_raw    = pick_word();
    p.nh3_raw    = pick_word();
    case ($urandom_range(3))
      0:       p.light_raw = 32'hFFFF_FFFF;
      1:       p.light_raw = 32'h0;
      default: p.light_raw = $urandom;
    endcase
    p.temp_raw  = pick_climate(sb.temp_lo, sb.temp_hi);
    p.humid_raw = pick_climate(sb.humid_lo, sb.humid_hi);
    return p;
  endfunction

  function automatic spm_in_t make_poll(logic [4:0] ok, logic [15:0] noise, logic [15:0] co2,
                                        logic [15:0] nh3, logic [31:0] light,
                                        logic [15:0] temp, logic [15:0] humid);
    spm_in_t p;
    p.noise_ok   = ok[OK_NOISE];
    p.co2_ok     = ok[OK_CO2];
    p.nh3_ok     = ok[OK_NH3];
    p.light_ok   = ok[OK_LIGHT];
    p.climate_ok = ok[OK_CLIMATE];
    p.noise_raw  = noise;
    p.co2_raw    = co2;
    p.nh3_raw    = nh3;
    p.light_raw  = light;
    p.temp_raw   = temp;
    p.humid_raw  = humid;
    return p;
  endfunction

  // Sends one poll request. Called and returns on a falling edge; valid stays
  // high on return, so requests sent without a gap never drop it in between.
  task automatic send_poll(spm_in_t p);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    sb.note_poll(p);
    @(negedge clk);
  endtask

  // Bursts of polls with a shared failure rate, so bad runs build up and
  // break off the way a flaky bus does.
  task automatic run_bursts(int count);
    int sent, burst, fail_pct;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(12, 1);
      case ($urandom_range(4))
        0:       fail_pct = 0;
        1:       fail_pct = 15;
        2:       fail_pct = 50;
        3:       fail_pct = 90;
        default: fail_pct = 100;
      endcase
      repeat (burst) begin
        send_poll(random_poll(fail_pct));
        sent++;
      end
    end
  endtask

  // Hold off the source until every expected result is back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One register write; starts and ends on a falling edge with the port idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    sb.set_register(idx, value);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_thresholds(int sensors, int cycles, int t_lo, int t_hi, int h_lo, int h_hi);
    // upper bits of the sensor threshold word are junk on purpose
    write_reg(CFG_FAIL_SENSOR_THR, {13'($urandom), 3'(sensors)});
    write_reg(CFG_FAIL_CYCLE_THR,  16'(cycles));
    write_reg(CFG_TEMP_LOW,        16'(t_lo));
    write_reg(CFG_TEMP_HIGH,       16'(t_hi));
    write_reg(CFG_HUMID_LOW,       16'(h_lo));
    write_reg(CFG_HUMID_HIGH,      16'(h_hi));
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    quiet       = 1'b0;
    idle_cycles = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset thresholds. Sound reads succeed in most of these so the
    // ring fills (16th sample) and a few baselines follow.
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFFF, 16'd800, 16'd1000));
    send_poll(make_poll(5'h1F, 16'h8000, 16'h8000, 16'h8000, 32'h0, -16'sd400, 16'd0));
    // one bound crossed at a time
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd5, 16'd7, 32'd1, 16'd801, 16'd500));
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd5, 16'd7, 32'd2, -16'sd401, 16'd500));
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd5, 16'd7, 32'd3, 16'd200, 16'd1001));
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd5, 16'd7, 32'd4, 16'd200, 16'hFFFF));
    // climate read failed: in-range raw values must still read as zero/invalid
    send_poll(make_poll(5'h0F, 16'h7FFF, 16'd9, 16'd9, 32'd9, 16'd200, 16'd500));
    // bad run: four failed sensors, three in a row trips the bus flag
    send_poll(make_poll(5'h01, 16'h7FFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd1, 16'd1));
    send_poll(make_poll(5'h01, 16'h7FFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd1, 16'd1));
    send_poll(make_poll(5'h01, 16'h7FFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd1, 16'd1));
    // exactly at the sensor threshold still counts as bad
    send_poll(make_poll(5'h03, 16'h7FFF, 16'd3, 16'hFFFF, 32'd0, 16'd1, 16'd1));
    // two failed: good cycle clears the run
    send_poll(make_poll(5'h07, 16'h7FFF, 16'd3, 16'd3, 32'd0, 16'd1, 16'd1));
    // all failed: every reading zero, sound ring untouched
    send_poll(make_poll(5'h00, 16'h1234, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 16'd1, 16'd1));
    // rest of the ring fill, then negative samples to hit truncation
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1F, 16'h7FFF, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1F, 16'h8000, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1F, 16'h8000, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1F, -16'sd3, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));
    send_poll(make_poll(5'h1E, 16'h7FFF, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0));

    // Random under the reset thresholds.
    run_bursts(60);
    drain();

    // Every cycle bad and bus flag stuck high; widest climate window.
    set_thresholds(0, 0, -32768, 32767, -32768, 32767);
    run_bursts(50);
    drain();

    // No cycle can be bad; inverted temperature window, one-point humidity.
    set_thresholds(7, 65535, 500, 100, 0, 0);
    run_bursts(50);
    drain();

    // Any single failure is bad and trips the flag at once.
    set_thresholds(1, 1, -400, 800, 200, 800);
    run_bursts(50);
    drain();

    // Bad only when everything failed; inverted humidity window.
    set_thresholds(5, 2, -100, 100, 900, -900);
    run_bursts(50);
    drain();

    // Threshold above the sensor count.
    set_thresholds(6, 4, 0, 0, -32768, 32767);
    run_bursts(50);
    drain();

    // Every cycle bad with a long cycle threshold, sent with no gaps and no
    // back-pressure: the flag rises partway through and stays up.
    set_thresholds(0, 30, -400, 800, 0, 1000);
    quiet = 1'b1;
    repeat (40) send_poll(random_poll(50));
    drain();
    quiet = 1'b0;

    // Mid-range settings to finish.
    set_thresholds(2, 5, -32768, 0, 0, 32767);
    run_bursts(50);
    drain();

    if (sb.pending_reports.size() != 0)
      sb.flag("results never returned", '0, 39'(sb.pending_reports.size()));
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
